>>> src/pvw_pkg.sv
// Shared types and constants for the peak and valley width tracker.
// Used by pvw_tracker and peak_valley_width_tracker_core; no dependencies.

package pvw_pkg;

    // width of each reported best width
    localparam int OUT_BITS = 20;

    // largest value a reported width can take
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // run direction codes
    typedef logic [1:0] pvw_dir_t;
    localparam pvw_dir_t DIR_NONE = 2'd0;
    localparam pvw_dir_t DIR_UP   = 2'd1;
    localparam pvw_dir_t DIR_DOWN = 2'd2;

    // pair of best widths handed from the tracker to the output register
    typedef struct packed {
        logic [OUT_BITS-1:0] valley;
        logic [OUT_BITS-1:0] peak;
    } pvw_widths_t;

endpackage

>>> src/peak_valley_width_tracker_core.sv
// Top level of the peak and valley width tracker: input register, tracker
// state and result register. Depends on pvw_pkg and pvw_tracker.
//
// Usage:
//   Samples enter on the s_ stream, one request per sample, with s_tlast set
//   on the final sample of a sequence. Each sample is compared with the one
//   before it and the rising and falling run counters are updated; strict
//   peaks and valleys are scored as min(run in, run out) and the largest of
//   each is kept. On the last sample one result request leaves on the m_
//   stream carrying both best widths, and the tracker starts a new sequence.
//   Throughput is one sample per cycle, except while a last sample waits on a
//   result not yet taken; the single compare and counter update between the input
//   register and the state/result registers sets it. m_tvalid rises once a last
//   sample leaves the input register; the result is held until it is taken.
//   Samples without s_tlast produce no result.
//   When m_tready is low with a result pending, non-last samples still flow;
//   a last sample waits in the input register until the result is taken,
//   and s_tready drops only while that register is held.
//   Reset clears all run state, best widths and both valid flags.

module peak_valley_width_tracker_core #(
    parameter int COUNT_BITS  = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample
    input  logic                                  s_tlast,  // last
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2*pvw_pkg::OUT_BITS-1:0]        m_tdata   // best_valley_width, best_peak_width
);

    import pvw_pkg::*;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    pvw_widths_t                   out_widths_reg;
    pvw_widths_t                   widths;
    logic                          advance;
    logic                          s_fire;

    // input register moves on unless a last sample meets a full result slot not being taken
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    // run tracking and scoring
    pvw_tracker #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .last   (in_last_reg),
        .widths (widths)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_widths_reg <= widths;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_widths_reg.valley, out_widths_reg.peak};

endmodule

>>> src/pvw_tracker.sv
// Run tracking and width scoring state for the peak and valley width tracker.
// Depends on pvw_pkg for direction codes and the widths struct.

module pvw_tracker #(
    parameter int COUNT_BITS  = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic                           last,
    output pvw_pkg::pvw_widths_t           widths
);

    import pvw_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                          have_prev_reg, have_prev_next;
    pvw_dir_t                      dir_reg, dir_next;
    logic [COUNT_BITS-1:0]         rise_reg, rise_next;
    logic [COUNT_BITS-1:0]         fall_reg, fall_next;
    logic [COUNT_BITS-1:0]         peak_left_reg, peak_left_next;
    logic [COUNT_BITS-1:0]         valley_left_reg, valley_left_next;
    logic                          peak_armed_reg, peak_armed_next;
    logic                          valley_armed_reg, valley_armed_next;
    logic [COUNT_BITS-1:0]         best_peak_reg, best_peak_next;
    logic [COUNT_BITS-1:0]         best_valley_reg, best_valley_next;

    logic [COUNT_BITS-1:0]         rise_inc, fall_inc;
    logic [COUNT_BITS-1:0]         peak_w, valley_w;
    logic [WIDE_BITS-1:0]          peak_wide, valley_wide;

    // saturating run increments
    assign rise_inc = (rise_reg == CNT_MAX) ? CNT_MAX : rise_reg + CNT_ONE;
    assign fall_inc = (fall_reg == CNT_MAX) ? CNT_MAX : fall_reg + CNT_ONE;

    // next tracking state for one sample
    always_comb
    begin
        prev_next         = sample;
        have_prev_next    = 1'b1;
        dir_next          = dir_reg;
        rise_next         = rise_reg;
        fall_next         = fall_reg;
        peak_left_next    = peak_left_reg;
        valley_left_next  = valley_left_reg;
        peak_armed_next   = peak_armed_reg;
        valley_armed_next = valley_armed_reg;
        best_peak_next    = best_peak_reg;
        best_valley_next  = best_valley_reg;
        peak_w            = '0;
        valley_w          = '0;

        if (have_prev_reg)
        begin
            if (sample > prev_reg)
            begin
                // rising step: a falling run that ends here arms a valley
                if (dir_reg == DIR_UP)
                begin
                    rise_next = rise_inc;
                end
                else
                begin
                    if (dir_reg == DIR_DOWN)
                    begin
                        valley_left_next  = fall_reg;
                        valley_armed_next = 1'b1;
                    end
                    rise_next = CNT_ONE;
                end
                peak_armed_next = 1'b0;
                fall_next       = '0;
                dir_next        = DIR_UP;
                valley_w = (valley_left_next < rise_next) ? valley_left_next : rise_next;
                if (valley_armed_next && (valley_w > best_valley_reg))
                begin
                    best_valley_next = valley_w;
                end
            end
            else if (sample < prev_reg)
            begin
                // falling step: a rising run that ends here arms a peak
                if (dir_reg == DIR_DOWN)
                begin
                    fall_next = fall_inc;
                end
                else
                begin
                    if (dir_reg == DIR_UP)
                    begin
                        peak_left_next  = rise_reg;
                        peak_armed_next = 1'b1;
                    end
                    fall_next = CNT_ONE;
                end
                valley_armed_next = 1'b0;
                rise_next         = '0;
                dir_next          = DIR_DOWN;
                peak_w = (peak_left_next < fall_next) ? peak_left_next : fall_next;
                if (peak_armed_next && (peak_w > best_peak_reg))
                begin
                    best_peak_next = peak_w;
                end
            end
            else
            begin
                // flat step breaks both runs
                rise_next         = '0;
                fall_next         = '0;
                peak_armed_next   = 1'b0;
                valley_armed_next = 1'b0;
                dir_next          = DIR_NONE;
            end
        end
    end

    // clamp best widths to the result field
    assign peak_wide   = WIDE_BITS'(best_peak_next);
    assign valley_wide = WIDE_BITS'(best_valley_next);
    assign widths.peak = (peak_wide > WIDE_BITS'(OUT_MAX)) ? OUT_MAX
                                                           : peak_wide[OUT_BITS-1:0];
    assign widths.valley = (valley_wide > WIDE_BITS'(OUT_MAX)) ? OUT_MAX
                                                               : valley_wide[OUT_BITS-1:0];

    // state registers; the last sample of a sequence returns all to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= '0;
            have_prev_reg    <= 1'b0;
            dir_reg          <= DIR_NONE;
            rise_reg         <= '0;
            fall_reg         <= '0;
            peak_left_reg    <= '0;
            valley_left_reg  <= '0;
            peak_armed_reg   <= 1'b0;
            valley_armed_reg <= 1'b0;
            best_peak_reg    <= '0;
            best_valley_reg  <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                prev_reg         <= '0;
                have_prev_reg    <= 1'b0;
                dir_reg          <= DIR_NONE;
                rise_reg         <= '0;
                fall_reg         <= '0;
                peak_left_reg    <= '0;
                valley_left_reg  <= '0;
                peak_armed_reg   <= 1'b0;
                valley_armed_reg <= 1'b0;
                best_peak_reg    <= '0;
                best_valley_reg  <= '0;
            end
            else
            begin
                prev_reg         <= prev_next;
                have_prev_reg    <= have_prev_next;
                dir_reg          <= dir_next;
                rise_reg         <= rise_next;
                fall_reg         <= fall_next;
                peak_left_reg    <= peak_left_next;
                valley_left_reg  <= valley_left_next;
                peak_armed_reg   <= peak_armed_next;
                valley_armed_reg <= valley_armed_next;
                best_peak_reg    <= best_peak_next;
                best_valley_reg  <= best_valley_next;
            end
        end
    end

endmodule
